// ----- sv/lrc_pkg.sv -----
// Shared types and constants for the line rasterizer with color interpolation.
// Used by lrc_div_lane, lrc_ctrl, lrc_datapath and line_raster_color_interp.
// No dependencies.
package lrc_pkg;

  localparam int COORD_W = 9;
  localparam int CH_W    = 8;
  localparam int NUM_CH  = 4;
  localparam int COLOR_W = CH_W * NUM_CH;
  localparam int ERR_W   = COORD_W + 1;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0] color_t;

  // Function codes on the input channel.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_start;
    logic do_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic major_zero;
    logic div_done;
  } status_t;

endpackage

// ----- sv/lrc_div_lane.sv -----
// One restoring divider lane: computes a signed color increment for one channel.
// Depends on lrc_pkg.
module lrc_div_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                start,
  input  logic                                step_en,
  input  logic                                finish,
  input  logic [lrc_pkg::CH_W-1:0]            ch_start,
  input  logic [lrc_pkg::CH_W-1:0]            ch_end,
  input  logic [lrc_pkg::COORD_W-1:0]         divisor,
  output logic signed [lrc_pkg::CH_W+FRAC_BITS:0] incr
);

  localparam int QW = lrc_pkg::CH_W + FRAC_BITS;

  logic [QW-1:0]                 quo;
  logic [lrc_pkg::COORD_W-1:0]   rem;
  logic                          neg;
  logic [lrc_pkg::COORD_W:0]     trial;
  logic                          q_bit;
  logic [lrc_pkg::COORD_W:0]     trial_sub;

  always_comb begin
    trial     = {rem, quo[QW-1]};
    trial_sub = trial - {1'b0, divisor};
    q_bit     = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= (ch_end < ch_start);
      quo <= {((ch_end < ch_start) ? (ch_start - ch_end) : (ch_end - ch_start)),
              {FRAC_BITS{1'b0}}};
      rem <= '0;
    end else if (step_en) begin
      rem <= q_bit ? trial_sub[lrc_pkg::COORD_W-1:0] : trial[lrc_pkg::COORD_W-1:0];
      quo <= {quo[QW-2:0], q_bit};
    end else if (finish) begin
      incr <= neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end
  end

endmodule

// ----- sv/lrc_ctrl.sv -----
// Controller state machine: input and output handshakes, divide wait.
// Depends on lrc_pkg.
module lrc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             func,
  output logic             out_valid,
  input  logic             out_ready,
  input  lrc_pkg::status_t status,
  output lrc_pkg::cmd_t    cmd
);

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.load_start = accept && (func == lrc_pkg::FUNC_START);
    cmd.do_step    = accept && (func == lrc_pkg::FUNC_STEP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.load_start && !status.major_zero) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (status.div_done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/lrc_datapath.sv -----
// Datapath: line set-up, Bresenham stepper, color accumulators, divider lanes
// and the output register. Depends on lrc_pkg and lrc_div_lane.
module lrc_datapath #(
  parameter int IMAGE_SIZE = 512,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lrc_pkg::cmd_t         cmd,
  output lrc_pkg::status_t      status,
  input  lrc_pkg::coord_t       start_x,
  input  lrc_pkg::coord_t       start_y,
  input  lrc_pkg::coord_t       end_x,
  input  lrc_pkg::coord_t       end_y,
  input  lrc_pkg::color_t       color_start,
  input  lrc_pkg::color_t       color_end,
  output logic                  valid_res,
  output lrc_pkg::coord_t       pixel_x,
  output lrc_pkg::coord_t       pixel_y,
  output lrc_pkg::color_t       pixel_color,
  output logic                  last
);

  localparam int QW    = lrc_pkg::CH_W + FRAC_BITS;
  localparam int SW    = QW + 2;
  localparam int CNT_W = $clog2(QW + 1);
  localparam logic [12:0] MAX_C = 13'(IMAGE_SIZE - 1);

  function automatic lrc_pkg::coord_t clamp_coord(input lrc_pkg::coord_t v);
    lrc_pkg::coord_t r;
    r = v;
    if ({4'b0000, v} > MAX_C) begin
      r = MAX_C[lrc_pkg::COORD_W-1:0];
    end
    return r;
  endfunction

  // Set-up values, computed from the input fields.
  lrc_pkg::coord_t x0, y0, x1, y1, dx, dy, s_major, s_minor;
  logic            s_xb, s_yb, s_xmaj;

  // Line state.
  lrc_pkg::coord_t cur_x, cur_y, major_len, minor_len, steps_left;
  logic            x_backward, y_backward, x_major, line_active;
  logic [lrc_pkg::ERR_W-1:0] error_term;
  lrc_pkg::color_t final_color;
  logic [QW-1:0]   color_accum [lrc_pkg::NUM_CH];
  logic signed [QW:0] color_incr [lrc_pkg::NUM_CH];

  // Step values.
  lrc_pkg::coord_t nx, ny, steps_next;
  logic [lrc_pkg::ERR_W-1:0] err_sum, err_next;
  logic [QW-1:0]   accum_next [lrc_pkg::NUM_CH];
  logic signed [SW-1:0] acc_sum [lrc_pkg::NUM_CH];
  lrc_pkg::color_t packed_next;

  // Divider sequencing.
  logic             div_busy;
  logic [CNT_W-1:0] div_cnt;
  logic             div_step, div_finish;

  always_comb begin
    x0     = clamp_coord(start_x);
    y0     = clamp_coord(start_y);
    x1     = clamp_coord(end_x);
    y1     = clamp_coord(end_y);
    s_xb   = (x1 < x0);
    s_yb   = (y1 < y0);
    dx     = s_xb ? (x0 - x1) : (x1 - x0);
    dy     = s_yb ? (y0 - y1) : (y1 - y0);
    s_xmaj = (dx > dy);
    s_major = s_xmaj ? dx : dy;
    s_minor = s_xmaj ? dy : dx;
  end

  always_comb begin
    status.major_zero = (s_major == '0);
    status.div_done   = div_finish;
  end

  assign div_step   = div_busy && (div_cnt != '0);
  assign div_finish = div_busy && (div_cnt == '0);

  // Bresenham step: the major coordinate always moves, the minor one when
  // the error term reaches the major length.
  always_comb begin
    err_sum  = error_term + {1'b0, minor_len};
    err_next = err_sum;
    nx = cur_x;
    ny = cur_y;
    if (x_major) begin
      nx = x_backward ? (cur_x - 1'b1) : (cur_x + 1'b1);
    end else begin
      ny = y_backward ? (cur_y - 1'b1) : (cur_y + 1'b1);
    end
    if (err_sum >= {1'b0, major_len}) begin
      err_next = err_sum - {1'b0, major_len};
      if (x_major) begin
        ny = y_backward ? (cur_y - 1'b1) : (cur_y + 1'b1);
      end else begin
        nx = x_backward ? (cur_x - 1'b1) : (cur_x + 1'b1);
      end
    end
    steps_next = steps_left - 1'b1;
  end

  // Saturating color accumulation.
  always_comb begin
    for (int i = 0; i < lrc_pkg::NUM_CH; i++) begin
      acc_sum[i] = $signed({2'b00, color_accum[i]}) +
                   $signed({color_incr[i][QW], color_incr[i]});
      if (acc_sum[i][SW-1]) begin
        accum_next[i] = '0;
      end else if (acc_sum[i][SW-2]) begin
        accum_next[i] = '1;
      end else begin
        accum_next[i] = acc_sum[i][QW-1:0];
      end
      packed_next[i*lrc_pkg::CH_W +: lrc_pkg::CH_W] = accum_next[i][QW-1 -: lrc_pkg::CH_W];
    end
  end

  for (genvar g = 0; g < lrc_pkg::NUM_CH; g++) begin : g_lane
    lrc_div_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .start   (cmd.load_start),
      .step_en (div_step),
      .finish  (div_finish),
      .ch_start(color_start[g*lrc_pkg::CH_W +: lrc_pkg::CH_W]),
      .ch_end  (color_end[g*lrc_pkg::CH_W +: lrc_pkg::CH_W]),
      .divisor (major_len),
      .incr    (color_incr[g])
    );
  end

  // Control state of the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      div_busy    <= 1'b0;
      div_cnt     <= '0;
    end else begin
      if (cmd.load_start) begin
        line_active <= (s_major != '0);
        div_busy    <= (s_major != '0);
        div_cnt     <= CNT_W'(QW);
      end else begin
        if (cmd.do_step && line_active) begin
          line_active <= (steps_next != '0);
        end
        if (div_step) begin
          div_cnt <= div_cnt - 1'b1;
        end else if (div_finish) begin
          div_busy <= 1'b0;
        end
      end
    end
  end

  // Line state and output register.
  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      cur_x       <= x0;
      cur_y       <= y0;
      x_backward  <= s_xb;
      y_backward  <= s_yb;
      x_major     <= s_xmaj;
      major_len   <= s_major;
      minor_len   <= s_minor;
      error_term  <= {2'b00, s_major[lrc_pkg::COORD_W-1:1]};
      steps_left  <= s_major;
      final_color <= color_end;
      for (int i = 0; i < lrc_pkg::NUM_CH; i++) begin
        color_accum[i] <= {color_start[i*lrc_pkg::CH_W +: lrc_pkg::CH_W],
                           {FRAC_BITS{1'b0}}};
      end
      valid_res   <= 1'b1;
      pixel_x     <= x0;
      pixel_y     <= y0;
      pixel_color <= (s_major == '0) ? color_end : color_start;
      last        <= (s_major == '0);
    end else if (cmd.do_step) begin
      if (line_active) begin
        cur_x      <= nx;
        cur_y      <= ny;
        error_term <= err_next;
        steps_left <= steps_next;
        for (int i = 0; i < lrc_pkg::NUM_CH; i++) begin
          color_accum[i] <= accum_next[i];
        end
        valid_res   <= 1'b1;
        pixel_x     <= nx;
        pixel_y     <= ny;
        pixel_color <= (steps_next == '0) ? final_color : packed_next;
        last        <= (steps_next == '0);
      end else begin
        valid_res   <= 1'b0;
        pixel_x     <= '0;
        pixel_y     <= '0;
        pixel_color <= '0;
        last        <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/line_raster_color_interp.sv -----
// Top level of the line rasterizer with per-channel RGBA color interpolation.
// Depends on lrc_pkg, lrc_ctrl, lrc_datapath and lrc_div_lane.
//
// Usage: the input channel carries one item per transfer. An item with func
// at the start code loads both endpoints and both packed colors and produces
// the first pixel of the line; each item with func at the step code produces
// the next pixel, with last set on the final pixel. A step while no line is
// active produces a result with valid_res low and all other fields zero.
//
// Every accepted item yields exactly one result, which appears in the output
// register on the cycle after the transfer. Step items sustain one per cycle
// while the receiver keeps up. After a start item of nonzero length, in_ready
// stays low while four restoring divider lanes, one quotient bit per cycle,
// work out the color increments; the first pixel is already on the output
// during that time. A zero-length line needs no divide.
// When the receiver stalls, the result holds in the output register and
// in_ready drops until that result is taken; a new item is accepted in the
// same cycle the waiting result transfers. Reset (synchronous, active high)
// leaves no line active and the output channel empty.
module line_raster_color_interp #(
  parameter int IMAGE_SIZE = 512,
  parameter int FRAC_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    func,
  input  logic [8:0]              start_x,
  input  logic [8:0]              start_y,
  input  logic [8:0]              end_x,
  input  logic [8:0]              end_y,
  input  logic [31:0]             color_start,
  input  logic [31:0]             color_end,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    valid_res,
  output logic [8:0]              pixel_x,
  output logic [8:0]              pixel_y,
  output logic [31:0]             pixel_color,
  output logic                    last
);

  lrc_pkg::cmd_t    cmd;
  lrc_pkg::status_t status;

  // The controller owns both handshakes and the wait for the divider.
  lrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the line state, the color lanes and the result.
  lrc_datapath #(
    .IMAGE_SIZE(IMAGE_SIZE),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .color_start(color_start),
    .color_end  (color_end),
    .valid_res  (valid_res),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_color(pixel_color),
    .last       (last)
  );

  // A start of nonzero length must hold off further items while dividing.
  a_div_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_start && !status.major_zero) |=> !in_ready)
    else $error("input accepted right after a line start that needs a divide");

  // The divider only finishes while the controller is waiting for it.
  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> !in_ready)
    else $error("divider finished while the input was open");

  // A result without a pixel carries all-zero fields.
  a_idle_step_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |->
      (pixel_x == '0 && pixel_y == '0 && pixel_color == '0 && !last))
    else $error("empty result carries nonzero fields");

  // The last flag only comes with an emitted pixel.
  a_last_has_pixel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> valid_res)
    else $error("last set on a result without a pixel");

endmodule

// ----- sim/line_raster_color_interp_tb.sv -----
// Self-checking testbench for line_raster_color_interp: directed and random line
// starts and pixel steps, with every result checked against a predictor in this file.
// Depends on lrc_pkg and the line_raster_color_interp RTL.
`timescale 1ns / 100ps

module line_raster_color_interp_tb;

  localparam int IMG       = 512;
  localparam int FRAC      = 16;
  localparam int LIMIT     = 400000;
  localparam int N_RANDOM  = 1500;
  localparam int DRAIN_GAP = 400;

  // One input item, in the order of the payload ports.
  typedef struct packed {
    logic            func;
    lrc_pkg::coord_t start_x;
    lrc_pkg::coord_t start_y;
    lrc_pkg::coord_t end_x;
    lrc_pkg::coord_t end_y;
    lrc_pkg::color_t color_start;
    lrc_pkg::color_t color_end;
  } line_item_t;

  // One result, in the order of the result ports.
  typedef struct packed {
    logic            valid_res;
    lrc_pkg::coord_t pixel_x;
    lrc_pkg::coord_t pixel_y;
    lrc_pkg::color_t pixel_color;
    logic            last;
  } pixel_t;

  // A queued item; the sender waits for all pixels to drain before offering
  // an item that carries the drain mark.
  typedef struct {
    line_item_t it;
    bit         drain;
  } pend_entry_t;

  typedef enum {RX_ON, RX_RAND, RX_SLOW, RX_HOLD} rx_mode_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic            func = lrc_pkg::FUNC_STEP;
  lrc_pkg::coord_t start_x = '0;
  lrc_pkg::coord_t start_y = '0;
  lrc_pkg::coord_t end_x = '0;
  lrc_pkg::coord_t end_y = '0;
  lrc_pkg::color_t color_start = '0;
  lrc_pkg::color_t color_end = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic            valid_res;
  lrc_pkg::coord_t pixel_x;
  lrc_pkg::coord_t pixel_y;
  lrc_pkg::color_t pixel_color;
  logic            last;

  line_raster_color_interp #(
    .IMAGE_SIZE(IMG),
    .FRAC_BITS (FRAC)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .color_start(color_start),
    .color_end  (color_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .valid_res  (valid_res),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_color(pixel_color),
    .last       (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Items still to be offered, and the pixels predicted for accepted items.
  pend_entry_t item_q[$];
  pixel_t      pixel_q[$];

  int errors = 0;
  int cycles = 0;
  int queued = 0;
  int n_results = 0;
  int n_starts = 0;
  int n_zero = 0;
  int n_steps = 0;
  int n_idle = 0;
  int n_lines_done = 0;
  int longest = 0;

  // ---------------------------------------------------------------------------
  // Predictor state: the rasterizer as it should look after every accepted item.
  // ---------------------------------------------------------------------------
  lrc_pkg::coord_t pos_x, pos_y;
  int              span_x, span_y;
  bit              x_dec, y_dec;
  int              err_acc;
  bit [9:0]        steps_rem;
  longint          chan_acc[4];
  longint          chan_inc[4];
  lrc_pkg::color_t end_color;
  bit              drawing;

  initial begin
    pos_x = '0;
    pos_y = '0;
    span_x = 0;
    span_y = 0;
    x_dec = 1'b0;
    y_dec = 1'b0;
    err_acc = 0;
    steps_rem = '0;
    end_color = '0;
    drawing = 1'b0;
    for (int ch = 0; ch < lrc_pkg::NUM_CH; ch++) begin
      chan_acc[ch] = 0;
      chan_inc[ch] = 0;
    end
  end

  // Advances the predictor by one item and returns the pixel it must produce.
  // With 9-bit coordinate ports and a 512-pixel image, no input coordinate can
  // lie beyond the image, so no coordinate clamping is needed here.
  function automatic pixel_t next_pixel(input line_item_t it);
    pixel_t          px;
    int              major;
    longint          s, e, a;
    lrc_pkg::color_t packed_color;
    px = '0;
    if (it.func == lrc_pkg::FUNC_START) begin
      x_dec = it.end_x < it.start_x;
      y_dec = it.end_y < it.start_y;
      span_x = x_dec ? int'(it.start_x) - int'(it.end_x) : int'(it.end_x) - int'(it.start_x);
      span_y = y_dec ? int'(it.start_y) - int'(it.end_y) : int'(it.end_y) - int'(it.start_y);
      // Ties go to y as the major axis.
      major = (span_x > span_y) ? span_x : span_y;
      err_acc = major / 2;
      steps_rem = major[9:0];
      end_color = it.color_end;
      pos_x = it.start_x;
      pos_y = it.start_y;
      for (int ch = 0; ch < lrc_pkg::NUM_CH; ch++) begin
        s = longint'(it.color_start[8*ch +: 8]);
        e = longint'(it.color_end[8*ch +: 8]);
        chan_acc[ch] = s <<< FRAC;
        // Signed division truncates toward zero, as the increment requires.
        chan_inc[ch] = (major == 0) ? 0 : ((e - s) <<< FRAC) / longint'(major);
      end
      drawing = (major != 0);
      px.valid_res = 1'b1;
      px.pixel_x = pos_x;
      px.pixel_y = pos_y;
      px.pixel_color = drawing ? it.color_start : it.color_end;
      px.last = !drawing;
    end else if (drawing) begin
      if (span_x > span_y) begin
        pos_x = x_dec ? pos_x - 1'b1 : pos_x + 1'b1;
        err_acc += span_y;
        if (err_acc >= span_x) begin
          pos_y = y_dec ? pos_y - 1'b1 : pos_y + 1'b1;
          err_acc -= span_x;
        end
      end else begin
        pos_y = y_dec ? pos_y - 1'b1 : pos_y + 1'b1;
        err_acc += span_x;
        if (err_acc >= span_y) begin
          pos_x = x_dec ? pos_x - 1'b1 : pos_x + 1'b1;
          err_acc -= span_y;
        end
      end
      for (int ch = 0; ch < lrc_pkg::NUM_CH; ch++) begin
        a = chan_acc[ch] + chan_inc[ch];
        if (a < 0) a = 0;
        if (a > (longint'(256) <<< FRAC) - 1) a = (longint'(256) <<< FRAC) - 1;
        chan_acc[ch] = a;
        packed_color[8*ch +: 8] = a[FRAC +: 8];
      end
      steps_rem = steps_rem - 1'b1;
      px.valid_res = 1'b1;
      px.pixel_x = pos_x;
      px.pixel_y = pos_y;
      if (steps_rem == 0) begin
        // The final pixel takes the end color exactly, not the accumulator.
        drawing = 1'b0;
        px.pixel_color = end_color;
        px.last = 1'b1;
      end else begin
        px.pixel_color = packed_color;
      end
    end
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------
  task automatic queue_start(input lrc_pkg::coord_t x0, input lrc_pkg::coord_t y0,
                             input lrc_pkg::coord_t x1, input lrc_pkg::coord_t y1,
                             input lrc_pkg::color_t c0, input lrc_pkg::color_t c1,
                             input bit drain);
    pend_entry_t ent;
    ent.it = '{func: lrc_pkg::FUNC_START, start_x: x0, start_y: y0, end_x: x1, end_y: y1,
               color_start: c0, color_end: c1};
    ent.drain = drain;
    item_q.push_back(ent);
    queued++;
  endtask

  // Step items carry random bits in the fields that the block ignores on a step.
  task automatic queue_steps(input int n);
    pend_entry_t ent;
    ent.drain = 1'b0;
    repeat (n) begin
      ent.it = '{func: lrc_pkg::FUNC_STEP, start_x: 9'($urandom), start_y: 9'($urandom),
                 end_x: 9'($urandom), end_y: 9'($urandom),
                 color_start: $urandom, color_end: $urandom};
      item_q.push_back(ent);
      queued++;
    end
  endtask

  // A coordinate within span of c, mirrored back into the image if needed.
  function automatic lrc_pkg::coord_t near_coord(input lrc_pkg::coord_t c, input int span);
    int d, v;
    d = $urandom_range(0, span);
    v = $urandom_range(0, 1) ? int'(c) + d : int'(c) - d;
    if (v < 0 || v > IMG - 1) v = 2 * int'(c) - v;
    return lrc_pkg::coord_t'(v);
  endfunction

  function automatic lrc_pkg::color_t pick_color();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers items from item_q in bursts with random gaps. An item with the
  // drain mark is held back until every predicted pixel has been received.
  // ---------------------------------------------------------------------------
  logic        in_fire = 1'b0;
  int          burst_left = 8;
  int          gap_left = 0;
  pend_entry_t offer;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (item_q.size() == 0 || (item_q[0].drain && pixel_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        offer = item_q.pop_front();
        {func, start_x, start_y, end_x, end_y, color_start, color_end} <= offer.it;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // An input transfer: remember it for the sender and predict its pixel.
  always @(posedge clk) begin
    in_fire <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      if (func == lrc_pkg::FUNC_START) begin
        n_starts++;
        if (start_x == end_x && start_y == end_y) n_zero++;
      end else if (drawing) begin
        n_steps++;
      end else begin
        n_idle++;
      end
      pixel_q.push_back(next_pixel({func, start_x, start_y, end_x, end_y,
                                    color_start, color_end}));
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: out_ready follows a pattern of segments of random mode and length.
  // Once enough pixels have come, one long hold-off lets the output back up into
  // the input while the sender keeps offering.
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_ON;
  int       rx_left = 0;
  bit       long_done = 1'b0;
  int       hold_max = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      if (!long_done && n_results > 400) begin
        rx_mode = RX_HOLD;
        rx_left = $urandom_range(150, 250);
        long_done = 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
        rx_mode = RX_HOLD;
        rx_left = $urandom_range(10, 40);
      end else begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_left = $urandom_range(5, 60);
      end
      if (rx_mode == RX_HOLD && rx_left > hold_max) hold_max = rx_left;
    end
    rx_left = rx_left - 1;
    case (rx_mode)
      RX_ON:   out_ready <= 1'b1;
      RX_RAND: out_ready <= 1'($urandom_range(0, 1));
      RX_SLOW: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor: every output transfer is checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  pixel_t want_px;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pixel_q.size() == 0) begin
        $error("pixel with no item pending: x %0d y %0d color 0x%0h",
               pixel_x, pixel_y, pixel_color);
        errors++;
      end else begin
        want_px = pixel_q.pop_front();
        check_field("valid_res", 32'(want_px.valid_res), 32'(valid_res));
        check_field("pixel_x", 32'(want_px.pixel_x), 32'(pixel_x));
        check_field("pixel_y", 32'(want_px.pixel_y), 32'(pixel_y));
        check_field("pixel_color", want_px.pixel_color, pixel_color);
        check_field("last", 32'(want_px.last), 32'(last));
        if (want_px.last) n_lines_done++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("line_raster_color_interp_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence: directed lines first, then random lines, then the drain.
  // ---------------------------------------------------------------------------
  lrc_pkg::coord_t x0, y0, x1, y1;
  int              pick, major, n_go, next_drain;
  bit              drain_mark;

  initial begin
    // A step with no line active, then zero-length lines at both image corners.
    queue_steps(1);
    queue_start(0, 0, 0, 0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    queue_steps(1);
    queue_start(511, 511, 511, 511, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    // Horizontal line going right, colors ramping up in every channel.
    queue_start(0, 511, 4, 511, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    queue_steps(4);
    // Vertical line going up, colors ramping down.
    queue_start(511, 511, 511, 508, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    queue_steps(3);
    // Exact diagonal: the tie makes y the major axis.
    queue_start(10, 10, 13, 7, 32'h1234_5678, 32'h8765_4321, 1'b0);
    queue_steps(3);
    // A full-diagonal line across the image, abandoned by a new start.
    queue_start(0, 511, 511, 0, 32'h00FF_00FF, 32'hFF00_FF00, 1'b0);
    queue_steps(2);
    queue_start(5, 0, 0, 2, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0);
    queue_steps(5);
    queue_steps(1);

    // Random lines: mostly short, some medium, a few across the whole image.
    // Most run to completion; some are cut short by the next start and some
    // are followed by stray steps.
    queued = 0;
    next_drain = 0;
    while (queued < N_RANDOM) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        queue_steps($urandom_range(1, 3));
      end else begin
        x0 = 9'($urandom);
        y0 = 9'($urandom);
        if (pick < 5) begin
          x1 = 9'($urandom);
          y1 = 9'($urandom);
        end else if (pick < 13) begin
          x1 = near_coord(x0, 100);
          y1 = near_coord(y0, 100);
        end else begin
          x1 = near_coord(x0, 12);
          y1 = near_coord(y0, 12);
        end
        major = (x1 > x0) ? x1 - x0 : x0 - x1;
        if (((y1 > y0) ? y1 - y0 : y0 - y1) > major) major = (y1 > y0) ? y1 - y0 : y0 - y1;
        if (major > longest) longest = major;
        n_go = major;
        pick = $urandom_range(0, 99);
        if (pick < 10 && major > 0) n_go = $urandom_range(0, major - 1);
        else if (pick < 16) n_go = major + $urandom_range(1, 2);
        drain_mark = (queued >= next_drain);
        if (drain_mark) next_drain = queued + DRAIN_GAP;
        queue_start(x0, y0, x1, y1, pick_color(), pick_color(), drain_mark);
        queue_steps(n_go);
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (item_q.size() != 0 || in_valid) @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    // Room for a divide still in flight and for any stray extra pixel.
    repeat (40) @(posedge clk);

    $display("Run covered %0d line starts (%0d zero-length), %0d drawing steps and %0d idle steps.",
             n_starts, n_zero, n_steps, n_idle);
    $display("%0d lines finished, longest random line %0d pixels, longest output hold %0d cycles.",
             n_lines_done, longest + 1, hold_max);
    if (errors == 0) begin
      $display("line_raster_color_interp_tb OK");
    end else begin
      $display("line_raster_color_interp_tb NOT OK");
    end
    $finish;
  end

endmodule
